FILE: rtl/kwm_pkg.sv
// Shared constants for the k-way merge min-heap unit.
package kwm_pkg;

  localparam int NUM_RUNS_DEF    = 16;
  localparam int VALUE_WIDTH_DEF = 32;
  localparam int PORT_VALUE_W    = 32;
  localparam int RUN_W           = 4;

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_ADVANCE = 1'b1;

endpackage

FILE: rtl/kwm_heap_ram.sv
// Heap storage: one write port, two registered read ports.
module kwm_heap_ram #(
  parameter int DEPTH = kwm_pkg::NUM_RUNS_DEF,
  parameter int WIDTH = kwm_pkg::VALUE_WIDTH_DEF + kwm_pkg::RUN_W,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

FILE: rtl/kway_merge_min_heap_unit.sv
// K-way merge min-heap unit: top level with sift sequencer and output register.
// Load: the element is written at the tail and sifted up towards the root; it is dropped
//   when the heap is full.
// Advance: an optional refill is inserted as a load, then the pop moves the last entry to the
//   root and sifts it down (at most 3 levels at 16 runs); an empty heap gives an underflow beat.
// One item at a time: in_ready stays low until the item is done; a held result stalls the pop.
// Reset (rst, synchronous): heap empty, sequencer idle, no result beat; memory not cleared.
module kway_merge_min_heap_unit #(
  parameter int NUM_RUNS    = kwm_pkg::NUM_RUNS_DEF,
  parameter int VALUE_WIDTH = kwm_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   cmd,
  input  logic signed [kwm_pkg::PORT_VALUE_W-1:0] value,
  input  logic [kwm_pkg::RUN_W-1:0]              run,
  input  logic                                   has_value,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [kwm_pkg::PORT_VALUE_W-1:0] min_value,
  output logic [kwm_pkg::RUN_W-1:0]              min_run,
  output logic                                   last,
  output logic                                   underflow
);

  localparam int PW   = kwm_pkg::PORT_VALUE_W;
  localparam int RW   = kwm_pkg::RUN_W;
  localparam int EW   = VALUE_WIDTH + RW;                     // {key, run}
  localparam int IW   = (NUM_RUNS > 1) ? $clog2(NUM_RUNS) : 1;
  localparam int CW   = $clog2(NUM_RUNS + 1);
  localparam int XW   = CW + 1;                               // child index range
  localparam int WIDE = (VALUE_WIDTH > PW) ? VALUE_WIDTH : PW;
  localparam logic [VALUE_WIDTH-1:0] SIGN_BIT = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
  localparam logic [CW-1:0] FULL = CW'(NUM_RUNS);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_UP     = 3'd1;
  localparam logic [2:0] S_UP_CMP = 3'd2;
  localparam logic [2:0] S_POP_RD = 3'd3;
  localparam logic [2:0] S_POP_LT = 3'd4;
  localparam logic [2:0] S_DN     = 3'd5;
  localparam logic [2:0] S_DN_CMP = 3'd6;
  localparam logic [2:0] S_EMIT   = 3'd7;

  logic [2:0]    state;
  logic [CW-1:0] cnt;
  logic [IW-1:0] idx;       // position of the hole being sifted
  logic [EW-1:0] elem;      // element travelling through the heap
  logic          adv;       // current item is an advance

  logic [PW-1:0] res_value;
  logic [RW-1:0] res_run;
  logic          res_last;
  logic          res_uf;

  // Memory ports
  logic          we;
  logic [IW-1:0] waddr;
  logic [EW-1:0] wdata;
  logic [IW-1:0] raddr_a;
  logic [IW-1:0] raddr_b;
  logic [EW-1:0] rdata_a;
  logic [EW-1:0] rdata_b;

  kwm_heap_ram #(
    .DEPTH (NUM_RUNS),
    .WIDTH (EW),
    .AW    (IW)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  // Input element: keep the low VALUE_WIDTH bits, flip the sign so keys compare unsigned.
  // Concatenating the run below the key makes ties fall to the lower run.
  logic [WIDE-1:0]        in_ext;
  logic [EW-1:0]          in_elem;
  assign in_ext  = WIDE'($unsigned(value));
  assign in_elem = {in_ext[VALUE_WIDTH-1:0] ^ SIGN_BIT, run};

  // Tree navigation
  logic [IW-1:0] parent;
  logic [XW-1:0] lx;
  logic [XW-1:0] rx;
  assign parent = (idx - IW'(1)) >> 1;
  assign lx     = {(XW-1)'(idx), 1'b1};
  assign rx     = lx + XW'(1);

  // Sift-up compare
  logic up_move;
  assign up_move = elem < rdata_a;

  // Sift-down compare: pick the smallest of hole element and both children
  logic          l_ok;
  logic          r_ok;
  logic          go_l;
  logic          go_r;
  logic [EW-1:0] best;
  logic          dn_move;
  logic [EW-1:0] child;
  logic [IW-1:0] child_idx;
  assign l_ok      = lx < XW'(cnt);
  assign r_ok      = rx < XW'(cnt);
  assign go_l      = l_ok && (rdata_a < elem);
  assign best      = go_l ? rdata_a : elem;
  assign go_r      = r_ok && (rdata_b < best);
  assign dn_move   = go_l || go_r;
  assign child     = go_r ? rdata_b : rdata_a;
  assign child_idx = go_r ? rx[IW-1:0] : lx[IW-1:0];

  // Popped top converted back to a two's complement port value
  logic [VALUE_WIDTH-1:0] top_raw;
  logic [WIDE-1:0]        top_ext;
  assign top_raw = rdata_a[EW-1:RW] ^ SIGN_BIT;
  assign top_ext = WIDE'($signed(top_raw));

  logic [CW-1:0] cnt_m1;
  assign cnt_m1 = cnt - CW'(1);

  always_comb begin
    we      = 1'b0;
    waddr   = idx;
    wdata   = elem;
    raddr_a = parent;
    raddr_b = parent;
    case (state)
      S_UP: begin
        we = (idx == '0);
      end
      S_UP_CMP: begin
        we    = 1'b1;
        wdata = up_move ? rdata_a : elem;
      end
      S_POP_RD: begin
        raddr_a = '0;
        raddr_b = cnt_m1[IW-1:0];
      end
      S_DN: begin
        raddr_a = lx[IW-1:0];
        raddr_b = rx[IW-1:0];
      end
      S_DN_CMP: begin
        we    = 1'b1;
        wdata = dn_move ? child : elem;
      end
      default: begin
      end
    endcase
  end

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      // Drop the result beat once the sink takes it; the emit state reloads it itself
      if (out_valid && out_ready && (state != S_EMIT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            adv  <= (cmd == kwm_pkg::CMD_ADVANCE);
            elem <= in_elem;
            idx  <= cnt[IW-1:0];
            if (((cmd == kwm_pkg::CMD_LOAD) || has_value) && (cnt < FULL)) begin
              cnt   <= cnt + CW'(1);
              state <= S_UP;
            end else if (cmd == kwm_pkg::CMD_ADVANCE) begin
              state <= S_POP_RD;
            end
          end
        end
        S_UP: begin
          // Hole at the root: the element was written this cycle
          if (idx == '0) begin
            state <= adv ? S_POP_RD : S_IDLE;
          end else begin
            state <= S_UP_CMP;
          end
        end
        S_UP_CMP: begin
          if (up_move) begin
            idx   <= parent;
            state <= S_UP;
          end else begin
            state <= adv ? S_POP_RD : S_IDLE;
          end
        end
        S_POP_RD: begin
          if (cnt == '0) begin
            res_value <= '0;
            res_run   <= '0;
            res_last  <= 1'b0;
            res_uf    <= 1'b1;
            state     <= S_EMIT;
          end else begin
            cnt   <= cnt_m1;
            state <= S_POP_LT;
          end
        end
        S_POP_LT: begin
          // Root and last entry have arrived; the last entry refills the root
          res_value <= top_ext[PW-1:0];
          res_run   <= rdata_a[RW-1:0];
          res_last  <= (cnt == '0);
          res_uf    <= 1'b0;
          elem      <= rdata_b;
          idx       <= '0;
          state     <= (cnt == '0) ? S_EMIT : S_DN;
        end
        S_DN: begin
          state <= S_DN_CMP;
        end
        S_DN_CMP: begin
          if (dn_move) begin
            idx   <= child_idx;
            state <= S_DN;
          end else begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          // Hold until the output register is free
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            min_value <= res_value;
            min_run   <= res_run;
            last      <= res_last;
            underflow <= res_uf;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the k-way merge min-heap unit.
`timescale 1ns / 100ps

module tb;

  localparam int DEPTH        = kwm_pkg::NUM_RUNS_DEF;
  localparam int PORT_VALUE_W = kwm_pkg::PORT_VALUE_W;
  localparam int RUN_W        = kwm_pkg::RUN_W;
  localparam int ITEM_TARGET  = 1400;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int TAIL_CYCLES  = 40;

  // One input beat and one result beat, at the port widths.
  typedef struct {
    logic                           cmd;
    logic signed [PORT_VALUE_W-1:0] value;
    logic [RUN_W-1:0]               run;
    logic                           has_value;
  } merge_item_t;

  typedef struct {
    logic signed [PORT_VALUE_W-1:0] min_value;
    logic [RUN_W-1:0]               min_run;
    logic                           last;
    logic                           underflow;
  } merge_result_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic                           cmd = kwm_pkg::CMD_LOAD;
  logic signed [PORT_VALUE_W-1:0] value = '0;
  logic [RUN_W-1:0]               run = '0;
  logic                           has_value = 1'b0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic signed [PORT_VALUE_W-1:0] min_value;
  logic [RUN_W-1:0]               min_run;
  logic                           last;
  logic                           underflow;

  kway_merge_min_heap_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .value     (value),
    .run       (run),
    .has_value (has_value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .min_value (min_value),
    .min_run   (min_run),
    .last      (last),
    .underflow (underflow)
  );

  always #6 clk = ~clk;

  merge_item_t   pending_items[$];
  merge_result_t expected_pops[$];

  // Predicted heap contents, kept in step with accepted input beats.
  logic signed [PORT_VALUE_W-1:0] heap_val[DEPTH];
  logic [RUN_W-1:0]               heap_run[DEPTH];
  int                             heap_size = 0;

  // Occupancy as seen by the stimulus builder while it fills the queue.
  int  gen_count = 0;
  bit  in_taken = 1'b0;
  bit  out_taken = 1'b0;
  int  in_gap = 0;
  int  out_gap = 0;
  int  in_beats = 0;
  int  out_beats = 0;
  int  cycle_count = 0;
  bit  failed = 1'b0;

  // ---------------------------------------------------------------------------
  // Heap predictor: signed compare, lower run wins a tie.
  // ---------------------------------------------------------------------------
  function automatic bit entry_before(input int a, input int b);
    if (heap_val[a] != heap_val[b]) return heap_val[a] < heap_val[b];
    return heap_run[a] < heap_run[b];
  endfunction

  function automatic void swap_slots(input int a, input int b);
    logic signed [PORT_VALUE_W-1:0] v;
    logic [RUN_W-1:0]               r;
    v = heap_val[a]; heap_val[a] = heap_val[b]; heap_val[b] = v;
    r = heap_run[a]; heap_run[a] = heap_run[b]; heap_run[b] = r;
  endfunction

  // Insert and sift up; drop the element when the heap is full.
  function automatic void heap_push(input logic signed [PORT_VALUE_W-1:0] v,
                                    input logic [RUN_W-1:0] r);
    int i;
    int p;
    if (heap_size >= DEPTH) return;
    i = heap_size;
    heap_val[i] = v;
    heap_run[i] = r;
    heap_size++;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (!entry_before(i, p)) break;
      swap_slots(i, p);
      i = p;
    end
  endfunction

  // Remove the minimum, move the tail to the root and sift down.
  function automatic void heap_pop_min(output logic signed [PORT_VALUE_W-1:0] v,
                                       output logic [RUN_W-1:0] r);
    int i;
    int l;
    int m;
    v = heap_val[0];
    r = heap_run[0];
    heap_size--;
    heap_val[0] = heap_val[heap_size];
    heap_run[0] = heap_run[heap_size];
    i = 0;
    forever begin
      l = 2 * i + 1;
      m = i;
      if (l < heap_size && entry_before(l, m)) m = l;
      if (l + 1 < heap_size && entry_before(l + 1, m)) m = l + 1;
      if (m == i) break;
      swap_slots(i, m);
      i = m;
    end
  endfunction

  // Work out what one accepted beat does; queue the result of an advance.
  function automatic void predict_merge_step(input merge_item_t it);
    merge_result_t res;
    if (it.cmd == kwm_pkg::CMD_LOAD) begin
      heap_push(it.value, it.run);
      return;
    end
    if (it.has_value) heap_push(it.value, it.run);
    res.min_value = '0;
    res.min_run   = '0;
    res.last      = 1'b0;
    res.underflow = 1'b0;
    if (heap_size == 0) begin
      res.underflow = 1'b1;
    end else begin
      heap_pop_min(res.min_value, res.min_run);
      res.last = (heap_size == 0);
    end
    expected_pops.insert(expected_pops.size(), res);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus building
  // ---------------------------------------------------------------------------
  function automatic void queue_item(input logic c, input logic signed [PORT_VALUE_W-1:0] v,
                                     input int r, input logic hv);
    merge_item_t it;
    it.cmd = c;
    it.value = v;
    it.run = RUN_W'(r);
    it.has_value = hv;
    pending_items.insert(pending_items.size(), it);
    if (c == kwm_pkg::CMD_LOAD || hv) begin
      if (gen_count < DEPTH) gen_count++;
    end
    if (c == kwm_pkg::CMD_ADVANCE && gen_count > 0) gen_count--;
  endfunction

  function automatic logic signed [PORT_VALUE_W-1:0] rand_value(input int spread);
    case (spread)
      0: return $signed($urandom_range(0, 8)) - 4;
      1: begin
        case ($urandom_range(0, 3))
          0: return 32'sh7fffffff;
          1: return 32'sh80000000;
          2: return '0;
          default: return $urandom;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  // Empty the heap, sometimes with one extra advance that underflows.
  function automatic void drain_heap();
    while (gen_count > 0)
      queue_item(kwm_pkg::CMD_ADVANCE, $urandom, $urandom_range(0, 15), 1'b0);
    if ($urandom_range(0, 2) == 0)
      queue_item(kwm_pkg::CMD_ADVANCE, $urandom, $urandom_range(0, 15), 1'b0);
  endfunction

  function automatic void add_noise(input int n);
    repeat (n)
      queue_item(1'($urandom_range(0, 1)), rand_value($urandom_range(0, 2)),
                 $urandom_range(0, 15), 1'($urandom_range(0, 1)));
    drain_heap();
  endfunction

  // A well-formed merge of k sorted runs: load the heads, then advance with
  // a refill of whichever run came out last until everything is out.
  function automatic void add_merge(input int k, input bit junk_when_full);
    logic signed [PORT_VALUE_W-1:0] run_data[DEPTH][$];
    logic signed [PORT_VALUE_W-1:0] head_val[DEPTH];
    logic signed [PORT_VALUE_W-1:0] v;
    bit  head_live[DEPTH];
    int  ids[DEPTH];
    int  spread;
    int  j;
    int  t;
    int  pick;
    int  refill;
    bit  first;
    bit  more;
    if (gen_count > 0) drain_heap();
    spread = $urandom_range(0, 2);
    for (int i = 0; i < DEPTH; i++) begin
      ids[i] = i;
      head_live[i] = 1'b0;
    end
    for (int i = DEPTH - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = ids[i]; ids[i] = ids[j]; ids[j] = t;
    end
    for (int i = 0; i < k; i++) begin
      repeat ($urandom_range(1, 8))
        run_data[ids[i]].insert(run_data[ids[i]].size(), rand_value(spread));
      run_data[ids[i]].sort();
      v = run_data[ids[i]].pop_front();
      queue_item(kwm_pkg::CMD_LOAD, v, ids[i], 1'($urandom_range(0, 1)));
      head_val[ids[i]] = v;
      head_live[ids[i]] = 1'b1;
    end
    // Full heap: this load must be dropped.
    if (junk_when_full && k == DEPTH)
      queue_item(kwm_pkg::CMD_LOAD, $urandom, $urandom_range(0, 15),
                 1'($urandom_range(0, 1)));
    refill = -1;
    first = 1'b1;
    do begin
      if (refill >= 0 && run_data[refill].size() > 0) begin
        v = run_data[refill].pop_front();
        queue_item(kwm_pkg::CMD_ADVANCE, v, refill, 1'b1);
        head_val[refill] = v;
        head_live[refill] = 1'b1;
      end else if (first && junk_when_full && k == DEPTH) begin
        // Refill into a full heap: dropped, the pop still happens.
        queue_item(kwm_pkg::CMD_ADVANCE, $urandom, $urandom_range(0, 15), 1'b1);
      end else begin
        queue_item(kwm_pkg::CMD_ADVANCE, $urandom, $urandom_range(0, 15), 1'b0);
      end
      first = 1'b0;
      pick = -1;
      for (int r = 0; r < DEPTH; r++)
        if (head_live[r] && (pick < 0 || head_val[r] < head_val[pick])) pick = r;
      head_live[pick] = 1'b0;
      refill = pick;
      more = (run_data[refill].size() > 0);
      for (int r = 0; r < DEPTH; r++) more |= head_live[r];
    end while (more);
  endfunction

  // Idle length: mostly none or short, now and then long; none in calm phases.
  function automatic int pick_gap(input bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // Input driver: change on the falling edge, hold until the beat is taken.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    merge_item_t it;
    logic        next_valid;
    if (!rst) begin
      next_valid = in_valid;
      if (!in_valid || in_taken) begin
        next_valid = 1'b0;
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending_items.size() > 0) begin
          it = pending_items.pop_front();
          cmd       <= it.cmd;
          value     <= it.value;
          run       <= it.run;
          has_value <= it.has_value;
          next_valid = 1'b1;
          in_gap = pick_gap((in_beats / 150) % 4 == 3);
        end
      end
      in_taken = 1'b0;
      in_valid <= next_valid;
    end
  end

  // Result side: raise ready, stall for a random while after each beat.
  always @(negedge clk) begin
    if (!rst) begin
      if (out_taken) begin
        out_taken = 1'b0;
        out_gap = pick_gap((out_beats / 110) % 4 == 1);
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: sample on the rising edge, predict on input beats and check
  // every result beat against the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    merge_item_t   it;
    merge_result_t exp_res;
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else if (!rst) begin
      if (out_valid && out_ready) begin
        out_taken = 1'b1;
        out_beats++;
        if (expected_pops.size() == 0) begin
          $error("result beat with nothing expected: min_value %0d min_run %0d",
                 min_value, min_run);
          failed = 1'b1;
        end else begin
          exp_res = expected_pops.pop_front();
          if (min_value !== exp_res.min_value) begin
            $error("min_value: expected %0d, got %0d", exp_res.min_value, min_value);
            failed = 1'b1;
          end
          if (min_run !== exp_res.min_run) begin
            $error("min_run: expected %0d, got %0d", exp_res.min_run, min_run);
            failed = 1'b1;
          end
          if (last !== exp_res.last) begin
            $error("last: expected %0d, got %0d", exp_res.last, last);
            failed = 1'b1;
          end
          if (underflow !== exp_res.underflow) begin
            $error("underflow: expected %0d, got %0d", exp_res.underflow, underflow);
            failed = 1'b1;
          end
        end
      end
      if (in_valid && in_ready) begin
        it.cmd = cmd;
        it.value = value;
        it.run = run;
        it.has_value = has_value;
        predict_merge_step(it);
        in_taken = 1'b1;
        in_beats++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset, directed items, random merges, then drain and report.
  // ---------------------------------------------------------------------------
  initial begin
    int r;
    int k;
    // Directed: extremes, a load that ignores has_value, a value tie broken
    // by run, refill before pop, the last flag, and pops from an empty heap.
    queue_item(kwm_pkg::CMD_LOAD, 32'sh7fffffff, 15, 1'b0);
    queue_item(kwm_pkg::CMD_LOAD, 32'sh80000000, 0, 1'b1);
    queue_item(kwm_pkg::CMD_LOAD, 32'sh00000000, 5, 1'b1);
    queue_item(kwm_pkg::CMD_LOAD, 32'sh00000000, 3, 1'b0);
    queue_item(kwm_pkg::CMD_ADVANCE, 32'sh12345678, 7, 1'b0);
    queue_item(kwm_pkg::CMD_ADVANCE, 32'shffffffff, 9, 1'b1);
    queue_item(kwm_pkg::CMD_ADVANCE, 32'sh00000000, 0, 1'b0);
    queue_item(kwm_pkg::CMD_ADVANCE, 32'shffffffff, 15, 1'b0);
    queue_item(kwm_pkg::CMD_ADVANCE, 32'sh55555555, 10, 1'b0);
    queue_item(kwm_pkg::CMD_ADVANCE, 32'shaaaaaaaa, 5, 1'b0);
    queue_item(kwm_pkg::CMD_ADVANCE, 32'sh0000002a, 12, 1'b1);
    queue_item(kwm_pkg::CMD_ADVANCE, 32'sh7fffffff, 15, 1'b0);
    queue_item(kwm_pkg::CMD_LOAD, 32'sh00000005, 2, 1'b1);
    queue_item(kwm_pkg::CMD_ADVANCE, 32'sh00000005, 1, 1'b1);
    queue_item(kwm_pkg::CMD_ADVANCE, 32'sh80000000, 0, 1'b0);

    // Random: mostly well-formed merges, some noise and empty pops.
    while (pending_items.size() < ITEM_TARGET) begin
      r = $urandom_range(0, 9);
      if (r < 7) begin
        k = ($urandom_range(0, 3) == 0) ? DEPTH : $urandom_range(1, DEPTH);
        add_merge(k, $urandom_range(0, 1));
      end else if (r < 9) begin
        add_noise($urandom_range(3, 20));
      end else begin
        repeat ($urandom_range(1, 3))
          queue_item(kwm_pkg::CMD_ADVANCE, $urandom, $urandom_range(0, 15), 1'b0);
      end
    end

    // Keep reset asserted, then release it on a falling edge.
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    wait (pending_items.size() == 0 && !in_valid && expected_pops.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (!failed && expected_pops.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
